// ===== rtl/core/pirl_pkg.sv =====
// ----------------------------------------------------------------------------
// pirl_pkg: shared types and constants for the positional list
// Request/result codes, field widths and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package pirl_pkg;

	// default sizing
	localparam int DEPTH_DEF      = 16;
	localparam int VALUE_BITS_DEF = 15;

	// fixed field widths on the channels
	localparam int REQ_W   = 3;
	localparam int POS_W   = 6;
	localparam int VAL_W   = 16;
	localparam int STAT_W  = 3;
	localparam int IDX_W   = 4;
	localparam int EVAL_W  = 15;
	localparam int CNT_W   = 5;

	typedef enum logic [REQ_W-1:0] {
		REQ_APPEND = 3'd0,
		REQ_DUMP   = 3'd1,
		REQ_CLEAR  = 3'd2,
		REQ_INSERT = 3'd3,
		REQ_REMOVE = 3'd4
	} req_kind_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK     = 3'd0,
		ST_FULL   = 3'd1,
		ST_EMPTY  = 3'd2,
		ST_BADPOS = 3'd3,
		ST_NEG    = 3'd4
	} status_t;

	// walk pointer load source
	typedef enum logic [1:0] {
		PI_COUNT = 2'd0,
		PI_POS   = 2'd1,
		PI_ZERO  = 2'd2
	} ptr_init_t;

	// read address relative to the walk pointer
	typedef enum logic [1:0] {
		RD_PTR  = 2'd0,
		RD_PREV = 2'd1,
		RD_NEXT = 2'd2
	} rd_sel_t;

	typedef struct packed {
		logic      load_req;
		logic      set_code;
		logic      ptr_load;
		ptr_init_t ptr_init;
		logic      ptr_step;
		logic      mem_re;
		rd_sel_t   rd_sel;
		logic      mem_we;
		logic      wr_new;
		logic      count_inc;
		logic      count_dec;
		logic      count_clr;
		logic      out_load;
		logic      out_dump;
	} cmd_t;

	typedef struct packed {
		logic [REQ_W-1:0] req_type;
		logic             chk_ok;
		logic             walk_done;
		logic             at_end;
		logic             out_free;
	} sts_t;

endpackage

// ===== rtl/core/pirl_req_if.sv =====
// ----------------------------------------------------------------------------
// pirl_req_if: request channel
// valid/ready handshake carrying one list request per beat.
// ----------------------------------------------------------------------------
interface pirl_req_if;
	logic                              valid;
	logic                              ready;
	logic [pirl_pkg::REQ_W-1:0]        req_type;
	logic [pirl_pkg::POS_W-1:0]        position;
	logic signed [pirl_pkg::VAL_W-1:0] value;

	modport source (output valid, req_type, position, value, input ready);
	modport sink   (input valid, req_type, position, value, output ready);
endinterface

// ===== rtl/core/pirl_rsp_if.sv =====
// ----------------------------------------------------------------------------
// pirl_rsp_if: result channel
// valid/ready handshake carrying one result beat.
// ----------------------------------------------------------------------------
interface pirl_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [pirl_pkg::STAT_W-1:0] status;
	logic [pirl_pkg::IDX_W-1:0]  entry_index;
	logic [pirl_pkg::EVAL_W-1:0] entry_value;
	logic [pirl_pkg::CNT_W-1:0]  item_count;
	logic                        last;

	modport source (output valid, status, entry_index, entry_value, item_count, last,
		input ready);
	modport sink   (input valid, status, entry_index, entry_value, item_count, last,
		output ready);
endinterface

// ===== rtl/core/pirl_ram.sv =====
// ----------------------------------------------------------------------------
// pirl_ram: generic single-port-write RAM
// One write and one read port, read data registered on read enable.
// ----------------------------------------------------------------------------
module pirl_ram #(
	parameter  int W  = 8,
	parameter  int D  = 16,
	localparam int AW = (D > 1) ? $clog2(D) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/pirl_ctrl.sv =====
// ----------------------------------------------------------------------------
// pirl_ctrl: request sequencer
// Decodes each request and steps the datapath through shifts, writes and beats.
// ----------------------------------------------------------------------------
module pirl_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  pirl_pkg::sts_t   sts,
	output pirl_pkg::cmd_t   cmd
);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_DECODE = 8'b0000_0010,
		S_SH_RD  = 8'b0000_0100,
		S_SH_WR  = 8'b0000_1000,
		S_PUT    = 8'b0001_0000,
		S_D_RD   = 8'b0010_0000,
		S_D_OUT  = 8'b0100_0000,
		S_RESP   = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   is_insert;

	assign is_insert = (sts.req_type == pirl_pkg::REQ_INSERT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load_req = 1'b1;
					state_d      = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.set_code = 1'b1;
				case (sts.req_type)
					pirl_pkg::REQ_APPEND: begin
						cmd.ptr_load = sts.chk_ok;
						cmd.ptr_init = pirl_pkg::PI_COUNT;
						state_d      = sts.chk_ok ? S_PUT : S_RESP;
					end
					pirl_pkg::REQ_INSERT: begin
						cmd.ptr_load = sts.chk_ok;
						cmd.ptr_init = pirl_pkg::PI_COUNT;
						state_d      = sts.chk_ok ? S_SH_RD : S_RESP;
					end
					pirl_pkg::REQ_REMOVE: begin
						cmd.ptr_load = sts.chk_ok;
						cmd.ptr_init = pirl_pkg::PI_POS;
						state_d      = sts.chk_ok ? S_SH_RD : S_RESP;
					end
					pirl_pkg::REQ_DUMP: begin
						cmd.ptr_load = sts.chk_ok;
						cmd.ptr_init = pirl_pkg::PI_ZERO;
						state_d      = sts.chk_ok ? S_D_RD : S_RESP;
					end
					pirl_pkg::REQ_CLEAR: begin
						cmd.count_clr = 1'b1;
						state_d       = S_RESP;
					end
					default: begin
						// unused codes: dropped without a result
						state_d = S_IDLE;
					end
				endcase
			end
			S_SH_RD: begin
				if (sts.walk_done) begin
					if (is_insert) begin
						state_d = S_PUT;
					end else begin
						cmd.count_dec = 1'b1;
						state_d       = S_RESP;
					end
				end else begin
					cmd.mem_re = 1'b1;
					cmd.rd_sel = is_insert ? pirl_pkg::RD_PREV : pirl_pkg::RD_NEXT;
					state_d    = S_SH_WR;
				end
			end
			S_SH_WR: begin
				cmd.mem_we   = 1'b1;
				cmd.ptr_step = 1'b1;
				state_d      = S_SH_RD;
			end
			S_PUT: begin
				cmd.mem_we    = 1'b1;
				cmd.wr_new    = 1'b1;
				cmd.count_inc = 1'b1;
				state_d       = S_RESP;
			end
			S_D_RD: begin
				cmd.mem_re = 1'b1;
				cmd.rd_sel = pirl_pkg::RD_PTR;
				state_d    = S_D_OUT;
			end
			S_D_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_dump = 1'b1;
					if (sts.at_end) begin
						state_d = S_IDLE;
					end else begin
						// prefetch next entry while this beat is sent
						cmd.mem_re   = 1'b1;
						cmd.rd_sel   = pirl_pkg::RD_NEXT;
						cmd.ptr_step = 1'b1;
					end
				end
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result loaded while output register busy");

	a_count_then_resp: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.count_inc || cmd.count_dec || cmd.count_clr) |=> state_q == S_RESP)
		else $error("count update not followed by result");

endmodule

// ===== rtl/core/pirl_dp.sv =====
// ----------------------------------------------------------------------------
// pirl_dp: list datapath
// Entry RAM, count, walk pointer, request register and result register.
// ----------------------------------------------------------------------------
module pirl_dp #(
	parameter int DEPTH      = pirl_pkg::DEPTH_DEF,
	parameter int VALUE_BITS = pirl_pkg::VALUE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pirl_pkg::cmd_t                    cmd,
	output pirl_pkg::sts_t                    sts,
	input  logic [pirl_pkg::REQ_W-1:0]        in_req_type,
	input  logic [pirl_pkg::POS_W-1:0]        in_position,
	input  logic signed [pirl_pkg::VAL_W-1:0] in_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [pirl_pkg::STAT_W-1:0]       out_status,
	output logic [pirl_pkg::IDX_W-1:0]        out_entry_index,
	output logic [pirl_pkg::EVAL_W-1:0]       out_entry_value,
	output logic [pirl_pkg::CNT_W-1:0]        out_item_count,
	output logic                              out_last
);

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CMPW = (CW > pirl_pkg::POS_W) ? CW : pirl_pkg::POS_W;

	// latched request
	logic [pirl_pkg::REQ_W-1:0]        type_q;
	logic [pirl_pkg::POS_W-1:0]        pos_q;
	logic signed [pirl_pkg::VAL_W-1:0] val_q;

	logic [CW-1:0]       count_q;
	logic [CW-1:0]       ptr_q;
	logic [CW-1:0]       ptr_inc;
	logic [CW-1:0]       ptr_dec;
	pirl_pkg::status_t   st_q;
	pirl_pkg::status_t   chk_code;

	logic [CMPW-1:0] pos_x;
	logic [CMPW-1:0] cnt_x;
	logic [CMPW-1:0] ptr_x;
	logic            full;
	logic            empty;
	logic            neg;

	logic [AW-1:0]         raddr;
	logic [VALUE_BITS-1:0] wdata;
	logic [VALUE_BITS-1:0] rdata;

	assign ptr_inc = ptr_q + CW'(1);
	assign ptr_dec = ptr_q - CW'(1);
	assign pos_x   = CMPW'(pos_q);
	assign cnt_x   = CMPW'(count_q);
	assign ptr_x   = CMPW'(ptr_q);
	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign neg     = val_q[pirl_pkg::VAL_W-1];

	// checks in request order
	always_comb begin
		case (type_q)
			pirl_pkg::REQ_APPEND: begin
				chk_code = full ? pirl_pkg::ST_FULL
					: (neg ? pirl_pkg::ST_NEG : pirl_pkg::ST_OK);
			end
			pirl_pkg::REQ_INSERT: begin
				chk_code = full ? pirl_pkg::ST_FULL
					: ((pos_x > cnt_x) ? pirl_pkg::ST_BADPOS
					: (neg ? pirl_pkg::ST_NEG : pirl_pkg::ST_OK));
			end
			pirl_pkg::REQ_REMOVE: begin
				chk_code = empty ? pirl_pkg::ST_EMPTY
					: ((pos_x >= cnt_x) ? pirl_pkg::ST_BADPOS : pirl_pkg::ST_OK);
			end
			pirl_pkg::REQ_DUMP: begin
				chk_code = empty ? pirl_pkg::ST_EMPTY : pirl_pkg::ST_OK;
			end
			default: begin
				chk_code = pirl_pkg::ST_OK;
			end
		endcase
	end

	assign sts.req_type  = type_q;
	assign sts.chk_ok    = (chk_code == pirl_pkg::ST_OK);
	assign sts.at_end    = (ptr_inc == count_q);
	assign sts.walk_done = (type_q == pirl_pkg::REQ_INSERT) ? (ptr_x == pos_x) : sts.at_end;
	assign sts.out_free  = !out_valid || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			type_q <= in_req_type;
			pos_q  <= in_position;
			val_q  <= in_value;
		end
		if (cmd.set_code) begin
			st_q <= chk_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ptr_q   <= '0;
		end else begin
			if (cmd.count_clr) begin
				count_q <= '0;
			end else if (cmd.count_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.count_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.ptr_load) begin
				case (cmd.ptr_init)
					pirl_pkg::PI_COUNT: ptr_q <= count_q;
					pirl_pkg::PI_POS:   ptr_q <= CW'(pos_q);
					default:            ptr_q <= '0;
				endcase
			end else if (cmd.ptr_step) begin
				ptr_q <= (type_q == pirl_pkg::REQ_INSERT) ? ptr_dec : ptr_inc;
			end
		end
	end

	always_comb begin
		case (cmd.rd_sel)
			pirl_pkg::RD_PREV: raddr = AW'(ptr_dec);
			pirl_pkg::RD_NEXT: raddr = AW'(ptr_inc);
			default:           raddr = AW'(ptr_q);
		endcase
	end

	assign wdata = cmd.wr_new ? VALUE_BITS'(val_q) : rdata;

	pirl_ram #(
		.W (VALUE_BITS),
		.D (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.mem_we),
		.waddr (AW'(ptr_q)),
		.wdata (wdata),
		.re    (cmd.mem_re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_item_count <= pirl_pkg::CNT_W'(count_q);
			if (cmd.out_dump) begin
				out_status      <= pirl_pkg::ST_OK;
				out_entry_index <= pirl_pkg::IDX_W'(ptr_q);
				out_entry_value <= pirl_pkg::EVAL_W'(rdata);
				out_last        <= sts.at_end;
			end else begin
				out_status      <= st_q;
				out_entry_index <= '0;
				out_entry_value <= '0;
				out_last        <= 1'b1;
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |->
			count_q == $past(count_q) + CW'(1) || count_q == $past(count_q) - CW'(1)
			|| count_q == '0)
		else $error("entry count jumped");

endmodule

// ===== rtl/core/positional_insert_remove_list.sv =====
// ----------------------------------------------------------------------------
// positional_insert_remove_list: ordered list with positional insert/remove
// Keeps up to DEPTH non-negative values; append, insert, remove, clear, dump.
// ----------------------------------------------------------------------------
// From request beat to first result registered: clear, rejected requests and a
// dump of an empty list go from decode straight to the result; append writes
// the new entry, dump reads the first; insert and remove shift the entries up
// or down (one RAM read plus one write per entry); insert then adds the value.
// A dump then sends one beat per cycle while the result side keeps taking.
// A new request is taken the cycle after the last result is registered.
// Reset clears the count and the sequencer; the entry RAM is not cleared.
// ----------------------------------------------------------------------------
module positional_insert_remove_list #(
	parameter int DEPTH      = pirl_pkg::DEPTH_DEF,
	parameter int VALUE_BITS = pirl_pkg::VALUE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	pirl_req_if.sink    req,
	pirl_rsp_if.source  rsp
);

	// command/status bundle between sequencer and datapath
	pirl_pkg::cmd_t cmd;
	pirl_pkg::sts_t sts;

	// Sequencer: one request at a time; it holds off the request side
	// while it walks the RAM or waits for the result register to drain.
	pirl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: entry RAM, count, walk pointer and the result register.
	// The result register decouples the result beat from the next request.
	pirl_dp #(
		.DEPTH      (DEPTH),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.in_req_type     (req.req_type),
		.in_position     (req.position),
		.in_value        (req.value),
		.out_valid       (rsp.valid),
		.out_ready       (rsp.ready),
		.out_status      (rsp.status),
		.out_entry_index (rsp.entry_index),
		.out_entry_value (rsp.entry_value),
		.out_item_count  (rsp.item_count),
		.out_last        (rsp.last)
	);

endmodule
